>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MOSA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define MOSA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

>>> rtl/core/mosa_pkg.sv
package mosa_pkg;

  localparam int MAX_LEN = 1024;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = IDX_W + 1;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int APB_W   = 32;
  localparam int ADDR_W  = 3;

  // register index, taken from paddr above the byte offset
  localparam logic REG_LENGTH = 1'b0;
  localparam logic [LEN_W-1:0] LENGTH_RST = LEN_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_FIRST  = 2'd0,
    CMD_WR_SECOND = 2'd1,
    CMD_FIND      = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_HOLD
  } srch_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srch_stat_t;

endpackage

>>> rtl/core/mosa_ram.sv
module mosa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/mosa_search.sv
module mosa_search import mosa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LEN_W-1:0]  len,
  input  logic              out_free,
  input  logic [DATA_W-1:0] rd_a,
  input  logic [DATA_W-1:0] rd_b,
  output logic [IDX_W-1:0]  raddr_a,
  output logic [IDX_W-1:0]  raddr_b,
  output logic [DATA_W-1:0] result,
  output srch_stat_t        stat
);

  srch_state_t state_r, state_nxt;
  logic [IDX_W-1:0]  alo_r, ahi_r, blo_r, bhi_r;
  logic [IDX_W-1:0]  alo_nxt, ahi_nxt, blo_nxt, bhi_nxt;
  logic [IDX_W-1:0]  ma_r, mb_r;
  logic              odd_r, fin_r;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [IDX_W:0]    sum_a, sum_b;
  logic [IDX_W-1:0]  ma, mb;
  logic              va_lt, va_eq;

  assign sum_a   = {1'b0, alo_r} + {1'b0, ahi_r};
  assign sum_b   = {1'b0, blo_r} + {1'b0, bhi_r};
  assign ma      = sum_a[IDX_W:1];
  assign mb      = sum_b[IDX_W:1];
  assign va_lt   = $signed(rd_a) < $signed(rd_b);
  assign va_eq   = rd_a == rd_b;
  assign raddr_a = ma;
  assign raddr_b = mb;
  assign result  = res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (fin_r || va_eq) state_nxt = S_HOLD;
        else                state_nxt = S_RD;
      end
      S_HOLD: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stat.busy = state_r != S_IDLE;
    stat.done = (state_r == S_HOLD) && out_free;
  end

  // range and result update
  always_comb begin
    alo_nxt = alo_r;
    ahi_nxt = ahi_r;
    blo_nxt = blo_r;
    bhi_nxt = bhi_r;
    res_nxt = res_r;
    case (state_r)
      S_IDLE: begin
        alo_nxt = '0;
        blo_nxt = '0;
        ahi_nxt = IDX_W'(len - LEN_W'(1));
        bhi_nxt = IDX_W'(len - LEN_W'(1));
      end
      S_CMP: begin
        if (fin_r) begin
          res_nxt = va_lt ? rd_a : rd_b;
        end else if (va_eq) begin
          res_nxt = rd_a;
        end else if (va_lt) begin
          // drop low part of first, high part of second
          alo_nxt = odd_r ? ma_r : ma_r + IDX_W'(1);
          bhi_nxt = mb_r;
        end else begin
          ahi_nxt = ma_r;
          blo_nxt = odd_r ? mb_r : mb_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alo_r <= alo_nxt;
    ahi_r <= ahi_nxt;
    blo_r <= blo_nxt;
    bhi_r <= bhi_nxt;
    res_r <= res_nxt;
    if (state_r == S_RD) begin
      ma_r  <= ma;
      mb_r  <= mb;
      odd_r <= ~(alo_r[0] ^ ahi_r[0]);
      fin_r <= (alo_r == ahi_r) && (blo_r == bhi_r);
    end
  end

endmodule

>>> rtl/core/median_of_two_sorted_arrays_unit.sv
// Lower median of two equal-length sorted arrays held in two 1024x32 RAMs.
// Write commands: one transaction per cycle while no search runs, no result.
// Find: halving rounds (RAM read, then compare), k rounds with
// k <= ceil(log2(length)) + 1, then a hold until the output register is free;
// each round reads first because each array RAM has a single, registered read port.
// Reset (rst_n low, synchronous): idle, no result pending, length = 1; RAMs
// keep their contents and are undefined until written.
module median_of_two_sorted_arrays_unit import mosa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input transaction channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [DATA_W-1:0] in_value,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_median,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [APB_W-1:0]  cfg_pwdata,
  output logic [APB_W-1:0]  cfg_prdata,
  output logic              cfg_pready
);

`include "assert_macros.svh"

  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  len_eff;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_median_r;
  logic              in_acc, cfg_wr;
  logic              we_a, we_b, start, out_free;
  logic [IDX_W-1:0]  raddr_a, raddr_b;
  logic [DATA_W-1:0] rd_a, rd_b, result;
  srch_stat_t        stat;

  // ---------------------------------------------------------------------
  // Configuration: one register, length, at byte address 0. pready is
  // tied high, so every access completes in its access phase.
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    len_nxt = len_r;
    if (cfg_wr && (cfg_paddr[2] == REG_LENGTH)) begin
      len_nxt = cfg_pwdata[LEN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_LENGTH) ? APB_W'(len_r) : '0;

  // Clamp length: zero acts as one, anything above the array size saturates.
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_LEN)) begin
      len_eff = LEN_W'(MAX_LEN);
    end else begin
      len_eff = len_r;
    end
  end

  // ---------------------------------------------------------------------
  // Input: accept transactions only while no search runs. Writes go
  // straight to the RAMs; a find starts the search sequencer. The unused
  // command code is taken and dropped.
  // ---------------------------------------------------------------------
  assign in_ready = ~stat.busy;
  assign in_acc   = in_valid && in_ready;
  assign we_a     = in_acc && (in_command == CMD_WR_FIRST);
  assign we_b     = in_acc && (in_command == CMD_WR_SECOND);
  assign start    = in_acc && (in_command == CMD_FIND);

  mosa_ram #(.DEPTH(MAX_LEN), .WIDTH(DATA_W)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (in_index),
    .wdata (in_value),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  mosa_ram #(.DEPTH(MAX_LEN), .WIDTH(DATA_W)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (in_index),
    .wdata (in_value),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  // Search sequencer: halves both ranges, one RAM read pair per round.
  mosa_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .len      (len_eff),
    .out_free (out_free),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .result   (result),
    .stat     (stat)
  );

  // ---------------------------------------------------------------------
  // Output register: hold the result until the consumer takes it; the
  // sequencer waits in its hold state while the register is occupied.
  // ---------------------------------------------------------------------
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (stat.done) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= LENGTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_median_r <= result;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `MOSA_ASSERT_IMP(a_done_into_free_slot, clk, rst_n, stat.done, out_free)
  `MOSA_ASSERT_NXT(a_find_starts_search, clk, rst_n, start, stat.busy)
  `MOSA_ASSERT_NXT(a_done_shows_result, clk, rst_n, stat.done,
                   out_valid && (out_median == $past(result)))

endmodule
